### rtl/core/sis_pkg.sv
// Shared state type for the systolic insertion sorter.
`default_nettype none

package sis_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

### rtl/core/sis_cell.sv
// One compare cell of the sorting chain: holds a key, forwards the smaller one.
`default_nettype none

module sis_cell #(
    parameter int KEY_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire logic                i_mv_valid,
    input  wire logic [KEY_BITS-1:0] i_mv_key,
    input  wire logic                i_next_full,
    input  wire logic [KEY_BITS-1:0] i_next_value,
    output logic                     o_mv_valid,
    output logic [KEY_BITS-1:0]      o_mv_key,
    output logic                     o_full,
    output logic [KEY_BITS-1:0]      o_value
);

    import sis_pkg::*;

    logic                r_full;
    logic [KEY_BITS-1:0] r_value;
    logic                r_mv_valid;
    logic [KEY_BITS-1:0] r_mv_key;
    logic                n_keep_new;

    assign n_keep_new = !r_full || (i_mv_key >= r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_mv_valid <= 1'b0;
        end else if (i_shift) begin
            r_full     <= i_next_full;
            r_mv_valid <= 1'b0;
        end else if (i_mv_valid) begin
            r_full     <= 1'b1;
            r_mv_valid <= r_full;
        end else begin
            r_mv_valid <= 1'b0;
        end
    end

    // advance the held key on readout, else keep the larger key and pass the other
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_next_value;
        end else if (i_mv_valid) begin
            if (n_keep_new) begin
                r_value  <= i_mv_key;
                r_mv_key <= r_value;
            end else begin
                r_mv_key <= i_mv_key;
            end
        end
    end

    assign o_mv_valid = r_mv_valid;
    assign o_mv_key   = r_mv_key;
    assign o_full     = r_full;
    assign o_value    = r_value;

endmodule

`default_nettype wire

### rtl/core/systolic_insertion_sorter.sv
// Top level of the systolic insertion sorter: cell chain and batch sequencer.
`default_nettype none
//
// Input channel: i_valid / o_stall carry i_key and i_batch_end. Keys of a
// batch may be transferred one per cycle; each ripples down the chain of
// CELLS cells, one cell per cycle, so several keys are in flight at once.
// The key that carries i_batch_end closes the batch: o_stall then rises and
// stays high until the whole batch has been read out.
// After the closing key the block waits in its flush state for keys in
// flight to settle, then presents the held keys on the output channel
// (o_valid / i_stall), largest first, one per cycle while i_stall is low.
// o_last_out marks the final key; o_overflow is set on every key of a batch
// that held more keys than cells (the smallest ones are lost).
// A batch of N keys gives min(N, CELLS) keys on the output channel.
// While i_stall is high the presented key holds and the chain does not move.
// Reset empties all cells, clears the overflow flag and opens the input.
//

module systolic_insertion_sorter #(
    parameter int CELLS    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic                i_batch_end,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [KEY_BITS-1:0]      o_sorted_key,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    import sis_pkg::*;

    localparam int CNT_W = $clog2(CELLS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_dropped;

    logic                n_in_xfer;
    logic                n_out_xfer;
    logic                n_shift;

    logic                mv_valid [CELLS+1];
    logic [KEY_BITS-1:0] mv_key   [CELLS+1];
    logic                full     [CELLS+1];
    logic [KEY_BITS-1:0] value    [CELLS+1];

    assign n_in_xfer  = i_valid && !o_stall;
    assign n_out_xfer = o_valid && !i_stall;
    assign n_shift    = n_out_xfer;

    assign mv_valid[0]  = n_in_xfer;
    assign mv_key[0]    = i_key;
    assign full[CELLS]  = 1'b0;
    assign value[CELLS] = '0;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        sis_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (n_shift),
            .i_mv_valid   (mv_valid[g]),
            .i_mv_key     (mv_key[g]),
            .i_next_full  (full[g+1]),
            .i_next_value (value[g+1]),
            .o_mv_valid   (mv_valid[g+1]),
            .o_mv_key     (mv_key[g+1]),
            .o_full       (full[g]),
            .o_value      (value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_LOAD: begin
                n_cnt = '0;
                if (n_in_xfer && i_batch_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_cnt == CNT_W'(CELLS)) begin
                    n_state = ST_READ;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_READ: begin
                if (n_out_xfer && o_last_out) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

    // drop: a key that leaves the last cell is lost for this batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropped <= 1'b0;
        end else if (n_out_xfer && o_last_out) begin
            r_dropped <= 1'b0;
        end else if (mv_valid[CELLS]) begin
            r_dropped <= 1'b1;
        end
    end

    assign o_stall      = (r_state != ST_LOAD);
    assign o_valid      = (r_state == ST_READ);
    assign o_sorted_key = value[0];
    assign o_last_out   = !full[1];
    assign o_overflow   = r_dropped;

endmodule

`default_nettype wire

### rtl/core/sis_checker.sv
// Port-level assertions for the systolic insertion sorter, bound to the top level.
`default_nettype none

module sis_checker #(
    parameter int KEY_BITS = 16
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                i_batch_end,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [KEY_BITS-1:0] o_sorted_key,
    input wire logic                o_last_out,
    input wire logic                o_overflow
);

    import sis_pkg::*;

    a_no_input_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while results are presented");

    a_close_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_batch_end) |=> (o_stall && !o_valid))
        else $error("batch close did not block input");

    a_last_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_out) |=> (!o_valid && !o_stall))
        else $error("output continued after last transfer");

    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_out) |=> $stable(o_overflow))
        else $error("overflow flag changed within a batch");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sorted_key) && $stable(o_last_out)))
        else $error("stalled result changed");

endmodule

bind systolic_insertion_sorter sis_checker #(
    .KEY_BITS (KEY_BITS)
) u_sis_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_batch_end  (i_batch_end),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sorted_key (o_sorted_key),
    .o_last_out   (o_last_out),
    .o_overflow   (o_overflow)
);

`default_nettype wire

### tb/systolic_insertion_sorter_test.sv
// Testbench for the systolic insertion sorter: queued stimulus, batch predictor, result check.
`timescale 1ns / 100ps

module systolic_insertion_sorter_test;

    localparam int CELLS       = 64;
    localparam int KEY_BITS    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = CELLS + 1;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic                batch_end;
        bit                  wait_drain;
    } t_key_xfer;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic                last;
        logic                ovf;
    } t_sorted_xfer;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [KEY_BITS-1:0] i_key       = '0;
    logic                i_batch_end = 1'b0;
    logic                i_stall     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [KEY_BITS-1:0] o_sorted_key;
    logic                o_last_out;
    logic                o_overflow;

    t_key_xfer    key_queue[$];
    t_sorted_xfer sorted_queue[$];

    logic [KEY_BITS-1:0] chain_key[CELLS];
    bit                  chain_full[CELLS];
    bit                  chain_lost;

    bit in_taken    = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;
    int sent_count  = 0;
    int rcv_count   = 0;
    int error_count = 0;
    int cycle_count = 0;

    systolic_insertion_sorter #(
        .CELLS    (CELLS),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key        (i_key),
        .i_batch_end  (i_batch_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sorted_key (o_sorted_key),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_key(input logic [KEY_BITS-1:0] key, input bit last, input bit drain);
        t_key_xfer x;
        x.key        = key;
        x.batch_end  = last;
        x.wait_drain = drain;
        key_queue.push_back(x);
    endtask

    function automatic logic [KEY_BITS-1:0] rand_key(input logic [KEY_BITS-1:0] prev);
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 9))
            6, 7:    k = KEY_BITS'($urandom_range(0, 7));
            8:       k = $urandom_range(0, 1) ? '1 : '0;
            9:       k = prev;
            default: k = KEY_BITS'($urandom);
        endcase
        return k;
    endfunction

    task automatic chain_insert(input logic [KEY_BITS-1:0] key);
        logic [KEY_BITS-1:0] moving;
        logic [KEY_BITS-1:0] held;
        bit                  placed;
        moving = key;
        placed = 1'b0;
        for (int i = 0; i < CELLS && !placed; i++) begin
            if (!chain_full[i]) begin
                chain_key[i]  = moving;
                chain_full[i] = 1'b1;
                placed        = 1'b1;
            end else if (moving >= chain_key[i]) begin
                held         = chain_key[i];
                chain_key[i] = moving;
                moving       = held;
            end
        end
        if (!placed) chain_lost = 1'b1;
    endtask

    task automatic chain_readout();
        t_sorted_xfer s;
        for (int i = 0; i < CELLS; i++) begin
            if (chain_full[i]) begin
                s.key  = chain_key[i];
                s.last = 1'b0;
                s.ovf  = chain_lost;
                sorted_queue.push_back(s);
            end
            chain_full[i] = 1'b0;
            chain_key[i]  = '0;
        end
        sorted_queue[sorted_queue.size()-1].last = 1'b1;
        chain_lost = 1'b0;
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Key channel driver
    always @(negedge i_clk) begin
        bit idle;
        idle = ($urandom_range(0, 99) < 16) && !(sent_count >= 100 && sent_count < 160);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold the stalled transfer
        end else if (key_queue.size() == 0 || idle ||
                     (key_queue[0].wait_drain && sorted_queue.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            i_valid     <= 1'b1;
            i_key       <= key_queue[0].key;
            i_batch_end <= key_queue[0].batch_end;
        end
    end

    // Key channel acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            in_taken <= 1'b1;
            chain_insert(i_key);
            if (i_batch_end) chain_readout();
            void'(key_queue.pop_front());
            sent_count++;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Result channel backpressure
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && rcv_count >= 30) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 16) && !(rcv_count >= 100 && rcv_count < 170);
        end
    end

    // Result channel check
    always @(posedge i_clk) begin
        t_sorted_xfer want;
        if (i_rst_n && o_valid && !i_stall) begin
            rcv_count++;
            if (sorted_queue.size() == 0) begin
                flag_error($sformatf("unexpected transfer key=%0h last=%0b ovf=%0b",
                                     o_sorted_key, o_last_out, o_overflow));
            end else begin
                want = sorted_queue.pop_front();
                if (o_sorted_key !== want.key || o_last_out !== want.last ||
                    o_overflow !== want.ovf) begin
                    flag_error($sformatf({"expected key=%0h last=%0b ovf=%0b, ",
                                          "got key=%0h last=%0b ovf=%0b"},
                                         want.key, want.last, want.ovf,
                                         o_sorted_key, o_last_out, o_overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("systolic_insertion_sorter test failed");
            $finish;
        end
    end

    initial begin
        logic [KEY_BITS-1:0] prev;
        int total;
        int batch_no;
        int size;
        int big_full;
        int big_over;
        bit drain;

        for (int i = 0; i < CELLS; i++) begin
            chain_key[i]  = '0;
            chain_full[i] = 1'b0;
        end
        chain_lost = 1'b0;

        add_key('0, 1'b1, 1'b0);
        add_key('1, 1'b1, 1'b0);
        add_key('1, 1'b0, 1'b0); add_key('0, 1'b0, 1'b0);
        add_key(16'h8000, 1'b0, 1'b0); add_key(16'h0001, 1'b1, 1'b0);
        add_key(16'd5, 1'b0, 1'b0); add_key(16'd5, 1'b0, 1'b0);
        add_key(16'd5, 1'b0, 1'b0); add_key(16'd5, 1'b1, 1'b0);
        add_key(16'd1, 1'b0, 1'b0); add_key(16'd2, 1'b0, 1'b0); add_key(16'd3, 1'b0, 1'b0);
        add_key(16'd4, 1'b0, 1'b0); add_key(16'd5, 1'b1, 1'b0);
        add_key(16'd9, 1'b0, 1'b1); add_key(16'd7, 1'b0, 1'b0); add_key(16'd3, 1'b1, 1'b0);

        total    = key_queue.size();
        batch_no = 0;
        prev     = '0;
        big_full = $urandom_range(2, 6);
        big_over = $urandom_range(8, 14);
        while (total < 250 || batch_no <= big_over) begin
            if (batch_no == big_full)
                size = CELLS;
            else if (batch_no == big_over)
                size = $urandom_range(CELLS + 1, CELLS + 6);
            else if ($urandom_range(0, 9) == 0)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(1, 12);
            drain = (batch_no == 0) || ($urandom_range(0, 9) == 0);
            for (int k = 0; k < size; k++) begin
                prev = rand_key(prev);
                add_key(prev, k == size - 1, drain && k == 0);
            end
            total += size;
            batch_no++;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (key_queue.size() != 0) @(posedge i_clk);
        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE + 20) @(posedge i_clk);

        if (sorted_queue.size() != 0) flag_error("results still outstanding at end of run");
        if (error_count == 0) begin
            $display("systolic_insertion_sorter test passed");
        end else begin
            $display("systolic_insertion_sorter test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/sis_pkg.sv
rtl/core/sis_cell.sv
rtl/core/systolic_insertion_sorter.sv
rtl/core/sis_checker.sv
tb/systolic_insertion_sorter_test.sv
